// ===== rtl/ipdfe_pkg.sv =====
// Shared types, codes and constants of the +IPD frame extractor.
package ipdfe_pkg;

	// Size limits of the frame search and of the length field.
	localparam int BUFFER_LIMIT = 512;
	localparam int MAX_PAYLOAD  = 2048;

	// Depth of the queue between the classifier and the parser.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Frame prefix "+IPD," and the other characters of interest.
	localparam int PREFIX_LEN = 5;
	localparam int PM_W       = $clog2(PREFIX_LEN + 1);
	localparam logic [7:0] PREFIX_TEXT [PREFIX_LEN] = '{8'h2B, 8'h49, 8'h50, 8'h44, 8'h2C};
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	// Widths of the internal counters.
	localparam int POS_W = 10;
	localparam int LEN_W = 16;
	localparam int ACC_W = 20;

	// Frame status codes.
	localparam logic [2:0] ST_PROGRESS = 3'd0;
	localparam logic [2:0] ST_DONE     = 3'd1;
	localparam logic [2:0] ST_NOPREFIX = 3'd2;
	localparam logic [2:0] ST_TRUNC    = 3'd3;
	localparam logic [2:0] ST_BADLEN   = 3'd4;

	typedef enum logic [1:0] {
		PH_SEARCH,
		PH_LENGTH,
		PH_DATA,
		PH_IDLE
	} phase_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       chunk_end;
	} item_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       is_payload;
		logic       payload_last;
		logic [2:0] frame_status;
	} result_t;

	// A received byte together with its character class.
	typedef struct packed {
		logic [7:0]            rx_byte;
		logic                  chunk_end;
		logic                  is_plus;
		logic                  is_colon;
		logic                  is_digit;
		logic [3:0]            digit;
		logic [PREFIX_LEN-1:0] prefix_hit;
	} cls_t;

endpackage

// ===== rtl/ipd_frame_extractor_core.sv =====
// Top level of the +IPD frame extractor: classifier, queue and parser.
//
// This block pulls the payload out of "+IPD,<len>:<data>" frames in a stream of
// received modem bytes. Each request carries one byte and a chunk_end flag that
// marks the last byte of a receive chunk. Within a chunk the block looks for the
// "+IPD," prefix among the first BUFFER_LIMIT bytes, reads the decimal length up
// to the ':' (which is not passed on), and then hands out that many payload bytes,
// flagging the last one. A frame that has no prefix, has a bad or oversized
// length, or ends before its payload is reported by a single status result with
// is_payload low; a payload cut short ends on a byte with ST_TRUNC. Bytes that
// produce nothing (prefix search, digits, idle bytes) yield no result. The block
// sustains one request per clock cycle unless the queue is full. A request passes
// through the queue to the parser, and its result, if any, is presented from an
// output register. A four-entry queue sits between the byte classifier and the
// parser, so requests keep being accepted while a result waits for result_ready;
// item_ready only drops when that queue is full. No clearing pass follows reset.
module ipd_frame_extractor_core
	import ipdfe_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	cls_t cls;
	cls_t head;
	logic full;
	logic empty;
	logic pop;

	// Character classes are worked out on the way into the queue, so the parser
	// only compares a few flag bits per byte.
	ipdfe_classify u_classify (
		.item (item),
		.cls  (cls)
	);

	assign item_ready = !full;

	ipdfe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (item_valid && item_ready),
		.push_data (cls),
		.full      (full),
		.pop       (pop),
		.empty     (empty),
		.head      (head)
	);

	// The parser runs the frame state machine and owns the result register.
	ipdfe_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (empty),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ===== rtl/ipdfe_classify.sv =====
// Front end: sorts each received byte into the character classes the parser needs.
module ipdfe_classify
	import ipdfe_pkg::*;
(
	input  item_t item,
	output cls_t  cls
);

	always_comb begin
		cls.rx_byte   = item.rx_byte;
		cls.chunk_end = item.chunk_end;
		cls.is_plus   = (item.rx_byte == CHAR_PLUS);
		cls.is_colon  = (item.rx_byte == CHAR_COLON);
		cls.is_digit  = (item.rx_byte >= CHAR_ZERO) && (item.rx_byte <= CHAR_NINE);
		cls.digit     = 4'(item.rx_byte - CHAR_ZERO);
		for (int i = 0; i < PREFIX_LEN; i++) begin
			cls.prefix_hit[i] = (item.rx_byte == PREFIX_TEXT[i]);
		end
	end

endmodule

// ===== rtl/ipdfe_queue.sv =====
// Short queue of classified bytes between the front end and the parser.
module ipdfe_queue
	import ipdfe_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  cls_t  push_data,
	output logic  full,
	input  logic  pop,
	output logic  empty,
	output cls_t  head
);

	cls_t              entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = (count_q == QCNT_W'(QDEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/ipdfe_parser.sv =====
// Back end: frame state machine and the registered result stage.
module ipdfe_parser
	import ipdfe_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    empty,
	input  cls_t    head,
	output logic    pop,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	phase_t            phase_q, phase_d;
	logic [PM_W-1:0]   pm_q, pm_d;
	logic [POS_W-1:0]  pos_q, pos_d;
	logic [LEN_W-1:0]  flen_q, flen_d;
	logic [LEN_W-1:0]  left_q, left_d;
	logic              res_valid;
	result_t           res;
	logic              out_valid_q;
	result_t           out_q;

	logic              hit;
	logic [PM_W-1:0]   pm_step;
	logic [POS_W-1:0]  pos_step;
	logic [ACC_W-1:0]  flen_w;
	logic [ACC_W-1:0]  acc_next;
	logic [LEN_W-1:0]  left_dec;

	// The parser takes the next byte whenever the result stage is free or drains.
	assign pop          = !empty && (!out_valid_q || result_ready);
	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH;
			pm_q    <= '0;
			pos_q   <= '0;
			flen_q  <= '0;
			left_q  <= '0;
		end else if (pop) begin
			phase_q <= phase_d;
			pm_q    <= pm_d;
			pos_q   <= pos_d;
			flen_q  <= flen_d;
			left_q  <= left_d;
		end
	end

	always_comb begin
		hit      = (pm_q < PM_W'(PREFIX_LEN)) && head.prefix_hit[pm_q];
		pm_step  = hit ? pm_q + 1'b1 : (head.is_plus ? PM_W'(1) : '0);
		pos_step = (pos_q < {POS_W{1'b1}}) ? pos_q + 1'b1 : pos_q;
		flen_w   = ACC_W'(flen_q);
		acc_next = (flen_w << 3) + (flen_w << 1) + ACC_W'(head.digit);
		left_dec = (left_q != '0) ? left_q - 1'b1 : left_q;

		phase_d   = phase_q;
		pm_d      = pm_q;
		pos_d     = pos_q;
		flen_d    = flen_q;
		left_d    = left_q;
		res_valid = 1'b0;
		res       = '0;

		unique case (phase_q)
			PH_SEARCH: begin
				pm_d  = pm_step;
				pos_d = pos_step;
				if (pm_step == PM_W'(PREFIX_LEN)) begin
					phase_d = PH_LENGTH;
					flen_d  = '0;
					if (head.chunk_end) begin
						res_valid        = 1'b1;
						res.frame_status = ST_TRUNC;
					end
				end else if (head.chunk_end || pos_step >= POS_W'(BUFFER_LIMIT)) begin
					phase_d          = PH_IDLE;
					res_valid        = 1'b1;
					res.frame_status = ST_NOPREFIX;
				end
			end
			PH_LENGTH: begin
				if (head.is_colon) begin
					if (flen_q == '0) begin
						phase_d          = PH_IDLE;
						res_valid        = 1'b1;
						res.frame_status = ST_DONE;
					end else begin
						phase_d = PH_DATA;
						left_d  = flen_q;
						if (head.chunk_end) begin
							res_valid        = 1'b1;
							res.frame_status = ST_TRUNC;
						end
					end
				end else if (head.is_digit) begin
					if (acc_next > ACC_W'(MAX_PAYLOAD)) begin
						phase_d          = PH_IDLE;
						res_valid        = 1'b1;
						res.frame_status = ST_BADLEN;
					end else begin
						flen_d = acc_next[LEN_W-1:0];
						if (head.chunk_end) begin
							res_valid        = 1'b1;
							res.frame_status = ST_TRUNC;
						end
					end
				end else begin
					phase_d          = PH_IDLE;
					res_valid        = 1'b1;
					res.frame_status = ST_BADLEN;
				end
			end
			PH_DATA: begin
				left_d           = left_dec;
				res_valid        = 1'b1;
				res.payload_byte = head.rx_byte;
				res.is_payload   = 1'b1;
				if (left_dec == '0) begin
					phase_d          = PH_IDLE;
					res.payload_last = 1'b1;
					res.frame_status = ST_DONE;
				end else begin
					res.frame_status = head.chunk_end ? ST_TRUNC : ST_PROGRESS;
				end
			end
			PH_IDLE: begin
			end
		endcase

		// The end of a receive chunk puts the parser back to its reset state.
		if (head.chunk_end) begin
			phase_d = PH_SEARCH;
			pm_d    = '0;
			pos_d   = '0;
			flen_d  = '0;
			left_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= res_valid;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && res_valid) begin
			out_q <= res;
		end
	end

	a_status_only_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.is_payload |-> out_q.payload_byte == '0 && !out_q.payload_last)
		else $error("status result carries payload bits");

	a_last_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.payload_last |-> out_q.is_payload && out_q.frame_status == ST_DONE)
		else $error("last payload byte without frame complete status");

	a_chunk_restart: assert property (@(posedge clk) disable iff (!arst_n)
		pop && head.chunk_end |=> phase_q == PH_SEARCH && pm_q == '0 && pos_q == '0)
		else $error("parser not restarted after chunk end");

	a_search_prefix_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SEARCH |-> pm_q < PM_W'(PREFIX_LEN))
		else $error("prefix count out of range while searching");

	a_data_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> left_q != '0)
		else $error("payload phase entered with nothing left to pass");

endmodule
